// ===== rtl/merge_sort_engine_top_defines.svh =====
// Assertion macros used by the merge sort engine checker.
`ifndef MERGE_SORT_ENGINE_TOP_DEFINES_SVH
`define MERGE_SORT_ENGINE_TOP_DEFINES_SVH

// Consequent must hold at the clock edge after the antecedent.
`define MSE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold at the same clock edge as the antecedent.
`define MSE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mse_pkg.sv =====
// Shared constants for the merge sort engine.
package mse_pkg;

    // Width of the value fields on both channels.
    localparam int DATA_BITS = 32;

    // Default batch capacity and stored value width.
    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_VALUE_BITS = 32;

endpackage

// ===== rtl/mse_if.sv =====
// Valid/ready channel interfaces for the item and result streams.
interface mse_in_if import mse_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] value;
    logic                        is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface mse_out_if import mse_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] sorted_value;
    logic                        last_out;
    logic                        dropped;

    modport source (output valid, output sorted_value, output last_out, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input dropped,
                    output ready);
endinterface

// ===== rtl/mse_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
module mse_ram import mse_pkg::*;
#(
    parameter int WIDTH = DEF_VALUE_BITS,
    parameter int DEPTH = DEF_MAX_ITEMS
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/merge_sort_engine_top.sv =====
// Merge sort engine top level: loads a batch, sorts it bottom-up in RAM, streams it out.
// Loading takes one item per cycle; a batch of n items then sorts in ceil(log2 n) passes,
// each merged element being read as the two run heads on the pair of read ports of the
// source RAM, then compared, with the smaller one written. Each result needs its own read
// and capture, so results do not leave back to back. Reset clears the sequencer,
// count and overflow flag at once; the two value RAMs are not cleared and need no clearing pass.
module merge_sort_engine_top import mse_pkg::*;
#(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    mse_in_if.sink    items,
    mse_out_if.source results
);

    // Address, count and widened-sum widths follow from the capacity.
    localparam int AW   = $clog2(MAX_ITEMS);
    localparam int CW   = $clog2(MAX_ITEMS + 1);
    localparam int SW   = CW + 2;
    localparam int WIDE = (VALUE_BITS > DATA_BITS) ? VALUE_BITS : DATA_BITS;

    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    // Sequencer states.
    localparam logic [2:0] ST_LOAD = 3'd0;  // accept items into the value store
    localparam logic [2:0] ST_RUN  = 3'd1;  // set up the bounds of the next pair of runs
    localparam logic [2:0] ST_MRD  = 3'd2;  // read both run heads
    localparam logic [2:0] ST_MCMP = 3'd3;  // compare heads, write the smaller one
    localparam logic [2:0] ST_ORD  = 3'd4;  // read the next sorted value
    localparam logic [2:0] ST_OCAP = 3'd5;  // capture it into the output register

    logic [2:0]      state_reg,   state_next;
    logic [CW-1:0]   count_reg,   count_next;
    logic            ovf_reg,     ovf_next;
    logic [CW-1:0]   width_reg,   width_next;
    logic [CW-1:0]   lo_reg,      lo_next;
    logic [CW-1:0]   mid_reg,     mid_next;
    logic [CW-1:0]   hi_reg,      hi_next;
    logic [CW-1:0]   i_reg,       i_next;
    logic [CW-1:0]   j_reg,       j_next;
    logic [CW-1:0]   k_reg,       k_next;
    logic            src_sel_reg, src_sel_next;
    logic            out_valid_reg, out_valid_next;

    logic [VALUE_BITS-1:0] out_val_reg,  out_val_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_drop_reg, out_drop_next;

    logic                  in_xfer;
    logic                  has_room;
    logic [WIDE-1:0]       in_wide;
    logic [VALUE_BITS-1:0] load_val;
    logic [WIDE-1:0]       out_wide;

    logic [SW-1:0]   sum_mid;
    logic [SW-1:0]   sum_hi;
    logic [CW-1:0]   mid_calc;
    logic [CW-1:0]   hi_calc;
    logic [CW:0]     width_dbl;
    logic [CW-1:0]   k_inc;
    logic [CW-1:0]   n_after;

    logic                  take_a;
    logic [VALUE_BITS-1:0] rd_a;
    logic [VALUE_BITS-1:0] rd_b;
    logic [VALUE_BITS-1:0] merge_val;

    // RAM ports. The store RAM holds the loaded batch; the scratch RAM is the
    // other half of the ping-pong pair used by the merge passes.
    logic [AW-1:0]         raddr_a;
    logic [AW-1:0]         raddr_b;
    logic                  sto_we;
    logic [AW-1:0]         sto_waddr;
    logic [VALUE_BITS-1:0] sto_wdata;
    logic [VALUE_BITS-1:0] sto_rd_a;
    logic [VALUE_BITS-1:0] sto_rd_b;
    logic                  scr_we;
    logic [VALUE_BITS-1:0] scr_rd_a;
    logic [VALUE_BITS-1:0] scr_rd_b;

    // Input bits above the stored width are ignored; narrower values are zero-extended.
    assign in_wide  = WIDE'($unsigned(items.value));
    assign load_val = in_wide[VALUE_BITS-1:0];
    assign has_room = (count_reg < MAX_CNT);

    // Items are taken only while loading. The output register stands on its
    // own, so the final result of a batch may still wait while loading resumes.
    assign items.ready = (state_reg == ST_LOAD);
    assign in_xfer     = items.valid && items.ready;

    assign out_wide             = WIDE'(out_val_reg);
    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_wide[DATA_BITS-1:0];
    assign results.last_out     = out_last_reg;
    assign results.dropped      = out_drop_reg;

    // Run bounds: mid = min(lo + width, n), hi = min(lo + 2 * width, n).
    assign sum_mid   = SW'(lo_reg) + SW'(width_reg);
    assign sum_hi    = SW'(lo_reg) + (SW'(width_reg) << 1);
    assign mid_calc  = (sum_mid < SW'(count_reg)) ? sum_mid[CW-1:0] : count_reg;
    assign hi_calc   = (sum_hi < SW'(count_reg)) ? sum_hi[CW-1:0] : count_reg;
    assign width_dbl = (CW + 1)'(width_reg) << 1;
    assign k_inc     = k_reg + 1'b1;
    assign n_after   = has_room ? CW'(count_reg + 1'b1) : count_reg;

    // The source of the current pass (and, after the last pass, the sorted
    // batch) is the store RAM when src_sel_reg is low, the scratch RAM otherwise.
    assign rd_a = src_sel_reg ? scr_rd_a : sto_rd_a;
    assign rd_b = src_sel_reg ? scr_rd_b : sto_rd_b;

    // Take the left head unless it is exhausted or, while the right run still has
    // items, strictly greater than the right head; equal values therefore keep their left-run order.
    assign take_a = (i_reg < mid_reg) &&
                    ((j_reg >= hi_reg) || !($signed(rd_a) > $signed(rd_b)));
    assign merge_val = take_a ? rd_a : rd_b;

    assign raddr_a = (state_reg == ST_ORD) ? k_reg[AW-1:0] : i_reg[AW-1:0];
    assign raddr_b = j_reg[AW-1:0];

    // Loading writes the store RAM; each merge write goes to the destination
    // side of the ping-pong pair.
    always_comb
    begin
        if (state_reg == ST_LOAD)
        begin
            sto_we    = in_xfer && has_room;
            sto_waddr = count_reg[AW-1:0];
            sto_wdata = load_val;
        end
        else
        begin
            sto_we    = (state_reg == ST_MCMP) && src_sel_reg;
            sto_waddr = k_reg[AW-1:0];
            sto_wdata = merge_val;
        end
    end

    assign scr_we = (state_reg == ST_MCMP) && !src_sel_reg;

    mse_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_store_ram (
        .clk     (clk),
        .we      (sto_we),
        .waddr   (sto_waddr),
        .wdata   (sto_wdata),
        .raddr_a (raddr_a),
        .rdata_a (sto_rd_a),
        .raddr_b (raddr_b),
        .rdata_b (sto_rd_b)
    );

    mse_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_scratch_ram (
        .clk     (clk),
        .we      (scr_we),
        .waddr   (k_reg[AW-1:0]),
        .wdata   (merge_val),
        .raddr_a (raddr_a),
        .rdata_a (scr_rd_a),
        .raddr_b (raddr_b),
        .rdata_b (scr_rd_b)
    );

    // Sequencer: load, then (for a batch of more than one item) merge passes of doubling run width, then output.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        src_sel_next   = src_sel_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;
        out_valid_next = out_valid_reg && !results.ready;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (has_room)
                    begin
                        count_next = n_after;
                    end
                    else
                    begin
                        // Store full: the item is discarded, even one marked last.
                        ovf_next = 1'b1;
                    end
                    if (items.is_last)
                    begin
                        src_sel_next = 1'b0;
                        width_next   = CW'(1);
                        lo_next      = '0;
                        k_next       = '0;
                        // A single item is already sorted.
                        state_next   = (n_after > CW'(1)) ? ST_RUN : ST_ORD;
                    end
                end
            end
            ST_RUN:
            begin
                mid_next   = mid_calc;
                hi_next    = hi_calc;
                i_next     = lo_reg;
                j_next     = mid_calc;
                k_next     = lo_reg;
                state_next = ST_MRD;
            end
            ST_MRD:
            begin
                state_next = ST_MCMP;
            end
            ST_MCMP:
            begin
                if (take_a)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
                k_next = k_inc;
                if (k_inc == hi_reg)
                begin
                    if (hi_reg == count_reg)
                    begin
                        // End of a pass: the destination becomes the next source.
                        src_sel_next = !src_sel_reg;
                        if (width_dbl >= (CW + 1)'(count_reg))
                        begin
                            k_next     = '0;
                            state_next = ST_ORD;
                        end
                        else
                        begin
                            width_next = width_dbl[CW-1:0];
                            lo_next    = '0;
                            state_next = ST_RUN;
                        end
                    end
                    else
                    begin
                        lo_next    = hi_reg;
                        state_next = ST_RUN;
                    end
                end
                else
                begin
                    state_next = ST_MRD;
                end
            end
            ST_ORD:
            begin
                // The read is issued once the output register frees up at this edge.
                if (!out_valid_reg || results.ready)
                begin
                    state_next = ST_OCAP;
                end
            end
            ST_OCAP:
            begin
                out_val_next   = rd_a;
                out_last_next  = (k_inc == count_reg);
                out_drop_next  = ovf_reg;
                out_valid_next = 1'b1;
                if (k_inc == count_reg)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = ST_ORD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            width_reg     <= '0;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            src_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            width_reg     <= width_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            src_sel_reg   <= src_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload carries no reset; it is qualified by the valid flag.
    always_ff @(posedge clk)
    begin
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

endmodule

// ===== rtl/mse_checker.sv =====
// Port-level checker for the merge sort engine, bound to the top level.
`include "merge_sort_engine_top_defines.svh"

module mse_checker import mse_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_valid,
    input logic                 item_ready,
    input logic                 item_last,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic [DATA_BITS-1:0] result_value,
    input logic                 result_last,
    input logic                 result_dropped
);

    logic item_xfer;
    logic result_xfer;

    assign item_xfer   = item_valid && item_ready;
    assign result_xfer = result_valid && result_ready;

    // A stalled result keeps its payload.
    `MSE_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable({result_value, result_last, result_dropped}), "stalled result changed")

    // The final item of a batch ends loading, so no item is taken next cycle.
    `MSE_ASSERT_NEXT(a_last_stops_load, item_xfer && item_last, !item_ready, "item taken right after the final item")

    // Each further result needs a fresh memory read, so none follows at once.
    `MSE_ASSERT_NEXT(a_result_gap, result_xfer && !result_last, !result_valid, "result offered right after a non-final transfer")

    // The batch is still being emitted after a non-final result.
    `MSE_ASSERT_NEXT(a_no_load_mid_batch, result_xfer && !result_last, !item_ready, "item taken while a batch is being emitted")

    // While loading, only the final result of the previous batch can still wait.
    `MSE_ASSERT_NOW(a_pending_is_final, item_ready && result_valid, result_last, "non-final result pending while loading")

endmodule

bind merge_sort_engine_top mse_checker u_mse_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (items.valid),
    .item_ready     (items.ready),
    .item_last      (items.is_last),
    .result_valid   (results.valid),
    .result_ready   (results.ready),
    .result_value   (results.sorted_value),
    .result_last    (results.last_out),
    .result_dropped (results.dropped)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the merge sort engine: batch loading, sorting order and overflow.
module tb;
    import mse_pkg::*;

    // The engine runs with its default capacity and value width.
    localparam int BATCH_CAP = DEF_MAX_ITEMS;

    // One item waiting to be offered on the load channel. A set drain_first
    // holds the item back until every sorted result already predicted has
    // been taken from the engine.
    typedef struct {
        logic signed [DATA_BITS-1:0] value;
        logic                        is_last;
        bit                          drain_first;
    } load_item_t;

    // One sorted value as the engine should emit it.
    typedef struct {
        logic signed [DATA_BITS-1:0] value;
        logic                        last_out;
        logic                        dropped;
    } sorted_result_t;

    logic clk;
    logic rst_n;

    mse_in_if  items_if ();
    mse_out_if results_if ();

    merge_sort_engine_top #(
        .MAX_ITEMS  (BATCH_CAP),
        .VALUE_BITS (DEF_VALUE_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if.sink),
        .results (results_if.source)
    );

    // Items still to be offered, and sorted results still owed by the engine.
    load_item_t     pending[$];
    sorted_result_t sorted_expect[$];

    // Shadow of the engine's batch store: the values loaded so far in the
    // current batch, how many of them fit, and whether any were lost.
    logic signed [DATA_BITS-1:0] batch_vals [BATCH_CAP];
    int                          batch_count;
    bit                          batch_overflow;

    int          err_cnt;
    int unsigned cycle_cnt;
    bit          item_taken;
    int          send_gap;
    int          stall_left;
    int          hold_left;
    bit          hold_done;
    int          hold_mark;
    bit          stim_ready;
    bit          quiet;

    // Clock with an 8 unit period.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // The run is cut short here if the engine stops making progress.
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Takes one transferred item into the shadow store. An item marked last
    // closes the batch: the stored values are put in ascending signed order by
    // insertion sort, and one result per stored value is queued, the final one
    // marked, every one flagged if the batch lost items. A batch that is full
    // drops further items, the one marked last included, yet that item still
    // closes the batch.
    task automatic sort_batch_item(input logic signed [DATA_BITS-1:0] value,
                                   input logic is_last);
        logic signed [DATA_BITS-1:0] key;
        sorted_result_t              res;
        int                          i;
        int                          j;
        if (batch_count < BATCH_CAP)
        begin
            batch_vals[batch_count] = value;
            batch_count++;
        end
        else
        begin
            batch_overflow = 1'b1;
        end
        if (is_last)
        begin
            for (i = 1; i < batch_count; i++)
            begin
                key = batch_vals[i];
                j = i - 1;
                while (j >= 0 && batch_vals[j] > key)
                begin
                    batch_vals[j + 1] = batch_vals[j];
                    j--;
                end
                batch_vals[j + 1] = key;
            end
            for (i = 0; i < batch_count; i++)
            begin
                res.value    = batch_vals[i];
                res.last_out = (i == batch_count - 1);
                res.dropped  = batch_overflow;
                sorted_expect.push_back(res);
            end
            batch_count    = 0;
            batch_overflow = 1'b0;
        end
    endtask

    // Values lean toward the two extremes and a narrow band around zero, so
    // that ties and sign handling come up often; the rest are fully random.
    function automatic logic signed [DATA_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       pick_value = {1'b1, {(DATA_BITS - 1){1'b0}}};
            1:       pick_value = {1'b0, {(DATA_BITS - 1){1'b1}}};
            2, 3:    pick_value = int'($urandom_range(0, 6)) - 3;
            default: pick_value = $urandom;
        endcase
    endfunction

    task automatic queue_item(input logic signed [DATA_BITS-1:0] value, input logic is_last,
                              input bit drain_first);
        load_item_t it;
        it.value       = value;
        it.is_last     = is_last;
        it.drain_first = drain_first;
        pending.push_back(it);
    endtask

    // A batch of n random values; the last one carries the end mark.
    task automatic queue_batch(input int n, input bit drain_first);
        int i;
        for (i = 0; i < n; i++)
        begin
            queue_item(pick_value(), i == n - 1, drain_first && i == 0);
        end
    endtask

    // Monitor: everything on both channels is sampled at the rising edge.
    // A load transfer goes into the predictor; a result transfer is checked
    // against the oldest outstanding expectation, field by field.
    always @(posedge clk)
    begin
        sorted_result_t want;
        if (rst_n)
        begin
            cycle_cnt++;
            if (items_if.valid && items_if.ready)
            begin
                sort_batch_item(items_if.value, items_if.is_last);
                item_taken = 1'b1;
            end
            if (results_if.valid && results_if.ready)
            begin
                if (sorted_expect.size() == 0)
                begin
                    $error("unexpected result: sorted_value %0d, last_out %0b, dropped %0b",
                           results_if.sorted_value, results_if.last_out, results_if.dropped);
                    err_cnt++;
                end
                else
                begin
                    want = sorted_expect.pop_front();
                    if (results_if.sorted_value !== want.value)
                    begin
                        $error("sorted_value: expected %0d, actual %0d",
                               want.value, results_if.sorted_value);
                        err_cnt++;
                    end
                    if (results_if.last_out !== want.last_out)
                    begin
                        $error("last_out: expected %0b, actual %0b",
                               want.last_out, results_if.last_out);
                        err_cnt++;
                    end
                    if (results_if.dropped !== want.dropped)
                    begin
                        $error("dropped: expected %0b, actual %0b",
                               want.dropped, results_if.dropped);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // The last stretch of stimulus runs with both sides at full rate.
    always @(negedge clk)
    begin
        quiet <= stim_ready && pending.size() < 40;
    end

    // Driver: the load channel changes only at the falling edge. An offered
    // item stays on the channel until it is transferred. Between items the
    // sender may take a random gap, except in calm stretches and at the end
    // of the run. While idle the payload carries random junk that the engine
    // has to ignore.
    always @(negedge clk)
    begin
        bit holding;
        if (!rst_n)
        begin
            items_if.valid   <= 1'b0;
            items_if.value   <= '0;
            items_if.is_last <= 1'b0;
        end
        else
        begin
            holding = items_if.valid && !item_taken;
            if (item_taken)
            begin
                pending.delete(0);
                item_taken = 1'b0;
            end
            if (holding)
            begin
                // Keep offering the same item.
            end
            else if (send_gap != 0 || pending.size() == 0 ||
                     (pending[0].drain_first && sorted_expect.size() != 0))
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                end
                items_if.valid   <= 1'b0;
                items_if.value   <= $urandom;
                items_if.is_last <= 1'($urandom_range(0, 1));
            end
            else if (!quiet && !cycle_cnt[7] && $urandom_range(0, 5) == 0)
            begin
                send_gap         <= $urandom_range(0, 14);
                items_if.valid   <= 1'b0;
                items_if.value   <= $urandom;
                items_if.is_last <= 1'($urandom_range(0, 1));
            end
            else
            begin
                items_if.valid   <= 1'b1;
                items_if.value   <= pending[0].value;
                items_if.is_last <= pending[0].is_last;
            end
        end
    end

    // One long hold-off of the result channel, started once the first few
    // items have gone in. The sender keeps offering meanwhile, so the engine
    // finishes a batch, cannot emit it, and has to stall its load channel.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (stim_ready && !hold_done && pending.size() <= hold_mark)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
    end

    // Receiver: ready changes at the falling edge, with random stall bursts
    // outside calm stretches and the end of the run.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            results_if.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left       <= stall_left - 1;
            results_if.ready <= 1'b0;
        end
        else if (!quiet && !cycle_cnt[8] && $urandom_range(0, 7) == 0)
        begin
            stall_left       <= $urandom_range(0, 14);
            results_if.ready <= 1'b0;
        end
        else
        begin
            results_if.ready <= 1'b1;
        end
    end

    initial
    begin
        int batch_idx;
        int n;
        int r;

        // Every input of the engine is known from time zero.
        rst_n            = 1'b0;
        items_if.valid   = 1'b0;
        items_if.value   = '0;
        items_if.is_last = 1'b0;
        results_if.ready = 1'b0;
        err_cnt          = 0;
        cycle_cnt        = 0;
        item_taken       = 1'b0;
        send_gap         = 0;
        stall_left       = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        stim_ready       = 1'b0;
        quiet            = 1'b0;
        batch_count      = 0;
        batch_overflow   = 1'b0;

        // Directed batches. A one-item batch at each extreme, where the end
        // mark comes on the very first item.
        queue_item({1'b0, {(DATA_BITS - 1){1'b1}}}, 1'b1, 1'b0);
        queue_item({1'b1, {(DATA_BITS - 1){1'b0}}}, 1'b1, 1'b0);
        // Two items in reverse order, largest first.
        queue_item({1'b0, {(DATA_BITS - 1){1'b1}}}, 1'b0, 1'b0);
        queue_item({1'b1, {(DATA_BITS - 1){1'b0}}}, 1'b1, 1'b0);
        // Ties around zero: equal values must all come out.
        queue_item(0, 1'b0, 1'b0);
        queue_item(-1, 1'b0, 1'b0);
        queue_item(0, 1'b0, 1'b0);
        queue_item(1, 1'b0, 1'b0);
        queue_item(-1, 1'b1, 1'b0);
        // A strictly descending run of eight.
        for (int v = 4; v >= -3; v--)
        begin
            queue_item(v, v == -3, 1'b0);
        end
        // Repeated extremes, interleaved.
        queue_item({1'b0, {(DATA_BITS - 1){1'b1}}}, 1'b0, 1'b0);
        queue_item({1'b1, {(DATA_BITS - 1){1'b0}}}, 1'b0, 1'b0);
        queue_item({1'b0, {(DATA_BITS - 1){1'b1}}}, 1'b0, 1'b0);
        queue_item({1'b1, {(DATA_BITS - 1){1'b0}}}, 1'b1, 1'b0);

        // A batch that exactly fills the store, then one whose marked last
        // item arrives with the store already full and is dropped.
        queue_batch(BATCH_CAP, 1'b0);
        queue_batch(BATCH_CAP + 1, 1'b0);

        // Random batches, mostly small, a few medium, and now and then one at
        // or past the capacity. The third one waits for the engine to drain.
        batch_idx = 0;
        while (pending.size() < 450)
        begin
            r = $urandom_range(0, 15);
            if (r == 0)
            begin
                n = $urandom_range(BATCH_CAP, BATCH_CAP + 6);
            end
            else if (r < 3)
            begin
                n = $urandom_range(13, 40);
            end
            else
            begin
                n = $urandom_range(1, 12);
            end
            queue_batch(n, batch_idx == 2);
            batch_idx++;
        end

        hold_mark  = pending.size() - 15;
        stim_ready = 1'b1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every item to be transferred, then for every result, then
        // give the engine a little longer to show any stray output.
        while (pending.size() != 0)
        begin
            @(posedge clk);
        end
        while (sorted_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);

        if (err_cnt == 0 && sorted_expect.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mse_pkg.sv
rtl/mse_if.sv
rtl/mse_ram.sv
rtl/merge_sort_engine_top.sv
rtl/mse_checker.sv
bench/tb.sv
